/* rtl/pdte_pkg.sv */
// ----------------------------------------------------------------------------
// pdte_pkg
// Shared types, constants and helpers for the packed date to epoch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pdte_pkg;

    // pipeline depth: stages 0..3 decode in the top, 4..7 count days
    localparam int NUM_STG = 8;
    localparam int DAY_STG = 4;

    // reset value of the current-year register
    localparam logic [11:0] CY_RESET = 12'd2025;

    // reciprocal multipliers (exact over the ranges used)
    localparam logic [31:0] DIV10K_MUL = 32'd3518437209; // x/10000 = (x*M)>>45, 32b x
    localparam int          DIV10K_SHR = 45;
    localparam logic [12:0] DIV100_MUL = 13'd5243;       // x/100 = (x*M)>>19, x<43699
    localparam logic [14:0] DIV25_MUL  = 15'd20972;      // x/25 = (x*M)>>19, 15b x

    localparam logic [10:0] ZIP_YEAR_BASE = 11'd2004;
    localparam logic [18:0] DEC_YEAR_MAX  = 19'd2100;
    localparam logic [15:0] MINS_PER_DAY  = 16'd1440;

    localparam logic [16:0] DEFAULT_TSEC  = 17'd54000;   // 15:00
    localparam logic [44:0] UTC8_SEC      = 45'd28800;

    // era*146097 + doe + day - DAY_BIAS = days since 1970-01-01
    // (bias folds in the 400-year year shift, the epoch offset and day-1)
    localparam logic [29:0] DAY_BIAS = 30'd865566;

    typedef struct packed {
        logic [DAY_STG-1:0] en;
    } t_pipe_ctl;

    // selected date handed to the day counter
    typedef struct packed {
        logic        bad;       // final month/day invalid: result is 0
        logic [18:0] yy_sh;     // March-based year plus 400
        logic [8:0]  doy;       // days from March 1 to the month start
        logic [4:0]  day;
        logic        clock_ok;  // minutes field carries the time
        logic [10:0] mins;
    } t_date;

    function automatic logic bad_md(input logic [6:0] m, input logic [6:0] d);
        bad_md = (m == 7'd0) || (m > 7'd12) || (d == 7'd0) || (d > 7'd31);
    endfunction

    // day offset of a month's first day in a March-based year
    function automatic logic [8:0] month_doy(input logic [3:0] m);
        case (m)
            4'd3:    month_doy = 9'd0;
            4'd4:    month_doy = 9'd31;
            4'd5:    month_doy = 9'd61;
            4'd6:    month_doy = 9'd92;
            4'd7:    month_doy = 9'd122;
            4'd8:    month_doy = 9'd153;
            4'd9:    month_doy = 9'd184;
            4'd10:   month_doy = 9'd214;
            4'd11:   month_doy = 9'd245;
            4'd12:   month_doy = 9'd275;
            4'd1:    month_doy = 9'd306;
            4'd2:    month_doy = 9'd337;
            default: month_doy = 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/pdte_day_count.sv */
// ----------------------------------------------------------------------------
// pdte_day_count
// Four-stage civil day count and seconds assembly for a selected date.
// ----------------------------------------------------------------------------
`default_nettype none

module pdte_day_count (
    input  wire                     i_clk,
    input  pdte_pkg::t_pipe_ctl     i_ctl,
    input  pdte_pkg::t_date         i_date,
    output logic signed [44:0]      o_epoch_seconds
);
    import pdte_pkg::*;

    // stage A: era = yy_sh / 400, time of day in seconds
    logic [29:0] era_prod;
    logic [10:0] r_a_era;
    logic [18:0] r_a_yy;
    logic [8:0]  r_a_doy;
    logic [4:0]  r_a_day;
    logic        r_a_bad;
    logic [16:0] r_a_tsec;

    assign era_prod = 30'(i_date.yy_sh[18:4]) * 30'(DIV25_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_a_era  <= era_prod[29:19];
            r_a_yy   <= i_date.yy_sh;
            r_a_doy  <= i_date.doy;
            r_a_day  <= i_date.day;
            r_a_bad  <= i_date.bad;
            r_a_tsec <= i_date.clock_ok ? 17'(17'(i_date.mins) * 17'd60) : DEFAULT_TSEC;
        end
    end

    // stage B: year of era and era base days
    logic [18:0] yoe_full;
    logic [8:0]  r_b_yoe;
    logic [27:0] r_b_base;
    logic [8:0]  r_b_doy;
    logic [4:0]  r_b_day;
    logic        r_b_bad;
    logic [16:0] r_b_tsec;

    assign yoe_full = r_a_yy - 19'(19'(r_a_era) * 19'd400);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_b_yoe  <= yoe_full[8:0];
            r_b_base <= 28'(28'(r_a_era) * 28'd146097);
            r_b_doy  <= r_a_doy;
            r_b_day  <= r_a_day;
            r_b_bad  <= r_a_bad;
            r_b_tsec <= r_a_tsec;
        end
    end

    // stage C: days since the epoch
    logic [1:0]         cent;
    logic [29:0]        day_sum;
    logic signed [29:0] r_c_days;
    logic               r_c_bad;
    logic [16:0]        r_c_tsec;

    assign cent = 2'(r_b_yoe >= 9'd100) + 2'(r_b_yoe >= 9'd200) + 2'(r_b_yoe >= 9'd300);
    assign day_sum = 30'(r_b_base) + 30'(30'(r_b_yoe) * 30'd365) + 30'(r_b_yoe[8:2])
                   - 30'(cent) + 30'(r_b_doy) + 30'(r_b_day) - DAY_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_c_days <= $signed(day_sum);
            r_c_bad  <= r_b_bad;
            r_c_tsec <= r_b_tsec;
        end
    end

    // stage D: seconds, shifted to UTC
    logic signed [44:0] days_x;
    logic signed [44:0] secs;

    assign days_x = 45'(r_c_days);
    assign secs   = days_x * 45'sd86400 + $signed(45'(r_c_tsec)) - $signed(UTC8_SEC);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            o_epoch_seconds <= r_c_bad ? 45'sd0 : secs;
        end
    end

endmodule

`default_nettype wire

/* rtl/packed_date_to_epoch_unit.sv */
// ----------------------------------------------------------------------------
// packed_date_to_epoch_unit
// Decodes a packed or decimal market-data date word into Unix seconds (UTC+8).
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  in       | i_valid / o_stall        | i_packed_value[31:0], i_has_time
//  out      | o_valid / i_stall        | o_epoch_seconds[44:0] (signed)
//  cfg      | i_cfg_valid / o_cfg_ready| i_year_cap[11:0]
//
//  One beat per cycle while the output is not stalled, through the eight
//  register stages (reciprocal divides, date select, day count, seconds).
//  Each stage moves when it is empty or the stage after it moves, so a
//  stall on the output fills bubbles before it reaches o_stall.
//  Reset (i_rst_n low, synchronous) empties the pipeline and loads
//  the year cap with 2025. o_cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_date_to_epoch_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input beats
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [31:0]         i_packed_value,
    input  wire                 i_has_time,
    // result beats
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [44:0]  o_epoch_seconds,
    // config write
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [11:0]         i_year_cap
);
    import pdte_pkg::*;

    // ---------------- config register ----------------
    logic [11:0] r_cy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy <= CY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cy <= i_year_cap;
        end
    end

    // ---------------- pipeline control ----------------
    // rdy[k]: stage k may load this cycle
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG:0]   rdy;

    always_comb begin
        rdy[NUM_STG] = !i_stall;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NUM_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: reciprocal multiplies ----------------
    // decimal year = v / 10000, packed month = (v[10:0]) / 100
    logic [63:0] q_prod;
    logic [23:0] mz_prod;
    logic [31:0] r0_v;
    logic        r0_ht;
    logic [18:0] r0_q;
    logic [4:0]  r0_mz;

    assign q_prod  = 64'(i_packed_value) * 64'(DIV10K_MUL);
    assign mz_prod = 24'(i_packed_value[10:0]) * 24'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_v  <= i_packed_value;
            r0_ht <= i_has_time;
            r0_q  <= q_prod[63:DIV10K_SHR];
            r0_mz <= mz_prod[23:19];
        end
    end

    // ---------------- stage 1: remainders ----------------
    logic [31:0] rem10k;
    logic [10:0] dz_full;
    logic        r1_ht;
    logic [18:0] r1_q;
    logic [13:0] r1_r;
    logic [4:0]  r1_yz;
    logic [4:0]  r1_mz;
    logic [6:0]  r1_dz;
    logic        r1_mins_ok;
    logic [10:0] r1_mins;

    assign rem10k  = r0_v - 32'(32'(r0_q) * 32'd10000);
    assign dz_full = r0_v[10:0] - 11'(11'(r0_mz) * 11'd100);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_ht      <= r0_ht;
            r1_q       <= r0_q;
            r1_r       <= rem10k[13:0];
            r1_yz      <= r0_v[15:11];
            r1_mz      <= r0_mz;
            r1_dz      <= dz_full[6:0];
            r1_mins_ok <= r0_v[31:16] < MINS_PER_DAY;  // hour <= 23
            r1_mins    <= r0_v[26:16];
        end
    end

    // ---------------- stage 2: decimal month ----------------
    logic [26:0] md_prod;
    logic        r2_ht;
    logic [18:0] r2_q;
    logic [13:0] r2_r;
    logic [6:0]  r2_md;
    logic [4:0]  r2_yz;
    logic [4:0]  r2_mz;
    logic [6:0]  r2_dz;
    logic        r2_mins_ok;
    logic [10:0] r2_mins;

    assign md_prod = 27'(r1_r) * 27'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_ht      <= r1_ht;
            r2_q       <= r1_q;
            r2_r       <= r1_r;
            r2_md      <= md_prod[25:19];
            r2_yz      <= r1_yz;
            r2_mz      <= r1_mz;
            r2_dz      <= r1_dz;
            r2_mins_ok <= r1_mins_ok;
            r2_mins    <= r1_mins;
        end
    end

    // ---------------- stage 3: pick packed or decimal reading ----------------
    logic [13:0] dd_full;
    logic [6:0]  dd;
    logic [10:0] yz;
    logic        zip_bad;
    logic        dec_bad;
    logic        use_zip;
    logic        clock_ok;
    logic [18:0] y_sel;
    logic [6:0]  m_sel;
    logic [6:0]  d_sel;
    logic        early;
    t_date       n3_date;
    t_date       r3_date;

    assign dd_full = r2_r - 14'(14'(r2_md) * 14'd100);
    assign dd      = dd_full[6:0];
    assign yz      = ZIP_YEAR_BASE + 11'(r2_yz);
    assign zip_bad = bad_md(7'(r2_mz), r2_dz);
    assign dec_bad = bad_md(r2_md, dd);

    always_comb begin
        if (r2_ht) begin
            // packed with clock unless it fails, then decimal at 15:00
            use_zip  = !(zip_bad || (12'(yz) > r_cy) || !r2_mins_ok);
            clock_ok = use_zip;
        end else begin
            // decimal first, packed at 15:00 as fallback
            use_zip  = (r2_q > DEC_YEAR_MAX) || dec_bad;
            clock_ok = 1'b0;
        end
        y_sel = use_zip ? 19'(yz) : r2_q;
        m_sel = use_zip ? 7'(r2_mz) : r2_md;
        d_sel = use_zip ? r2_dz : dd;
        early = (m_sel <= 7'd2);   // Jan/Feb count with the previous year

        n3_date.bad      = bad_md(m_sel, d_sel);
        n3_date.yy_sh    = y_sel + 19'd400 - 19'(early);
        n3_date.doy      = month_doy(m_sel[3:0]);
        n3_date.day      = d_sel[4:0];
        n3_date.clock_ok = clock_ok;
        n3_date.mins     = r2_mins;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_date <= n3_date;
        end
    end

    // ---------------- stages 4..7: day count and seconds ----------------
    t_pipe_ctl day_ctl;

    assign day_ctl.en = rdy[NUM_STG-1:NUM_STG-DAY_STG];

    pdte_day_count u_day_count (
        .i_clk           (i_clk),
        .i_ctl           (day_ctl),
        .i_date          (r3_date),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for packed_date_to_epoch_unit: drives packed and decimal date
// words through the input channel, predicts each epoch result in the bench
// and compares it against the output channel, with random idle on both sides.
// ----------------------------------------------------------------------------

module tb;

    localparam int PIPE_LAT   = 8;          // stages from input beat to result
    localparam int CLK_HALF   = 4;          // 8 ns clock
    localparam int TIMEOUT_NS = 10_000_000; // well past the slowest legal run
    localparam int MAX_PRINTS = 20;

    // decode constants
    localparam longint ZIP_BASE_YEAR = 2004;
    localparam longint DEC_YEAR_MAX  = 2100;
    localparam longint DEFAULT_HOUR  = 15;
    localparam longint LAST_HOUR     = 23;
    localparam longint UTC8_OFFSET   = 8 * 3600;

    // config range
    localparam logic [11:0] YEAR_CAP_MIN   = 12'd2004;
    localparam logic [11:0] YEAR_CAP_MAX   = 12'd2100;
    localparam logic [11:0] YEAR_CAP_RESET = 12'd2025;

    // one expected result, with the beat that caused it for the log
    typedef struct {
        logic [31:0]        word;
        logic               has_time;
        logic signed [44:0] secs;
    } t_epoch_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [31:0]        i_packed_value;
    logic               i_has_time;
    logic               o_valid;
    logic               i_stall;
    logic signed [44:0] o_epoch_seconds;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [11:0]        i_year_cap;

    t_epoch_beat pending_epochs[$];
    logic [11:0] year_cap;        // bench copy of the year cap register

    int n_words_sent;
    int n_epochs_checked;
    int n_cfg_writes;
    int n_input_blocked;          // cycles the unit pushed back on a valid beat
    int n_errors;

    int src_idle_pct;             // chance of a gap before an input beat
    int sink_stall_pct;           // chance of a stall run on the output
    int hold_left;                // long output hold-off, in cycles
    int stall_left;

    packed_date_to_epoch_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_packed_value  (i_packed_value),
        .i_has_time      (i_has_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_epoch_seconds (o_epoch_seconds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_year_cap      (i_year_cap)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic bit md_invalid(input longint mon, input longint dom);
        return mon < 1 || mon > 12 || dom < 1 || dom > 31;
    endfunction

    // zip form: year offset in [15:11], month*100+day in [10:0]
    function automatic void split_zip(input logic [31:0] word,
                                      output longint yr, output longint mon,
                                      output longint dom);
        longint md;
        md  = word[10:0];
        yr  = longint'(word[15:11]) + ZIP_BASE_YEAR;
        mon = md / 100;
        dom = md % 100;
    endfunction

    // decimal YYYYMMDD
    function automatic void split_decimal(input logic [31:0] word,
                                          output longint yr, output longint mon,
                                          output longint dom);
        longint w;
        w   = word;
        yr  = w / 10000;
        mon = (w % 10000) / 100;
        dom = w % 100;
    endfunction

    // Epoch seconds for one date word, local time at UTC+8. Day past month
    // end rolls forward since it is just added to the month start.
    function automatic logic signed [44:0] epoch_from_word(input logic [31:0] word,
                                                           input logic carries_time,
                                                           input logic [11:0] cap);
        longint yr, mon, dom, hr, mn, cap_l, mins;
        longint yy, era, yoe, mp, days, secs;
        cap_l = cap;
        hr    = DEFAULT_HOUR;
        mn    = 0;
        if (carries_time) begin
            split_zip(word, yr, mon, dom);
            mins = word[31:16];
            hr   = mins / 60;
            mn   = mins % 60;
            if (md_invalid(mon, dom) || yr > cap_l || hr > LAST_HOUR) begin
                split_decimal(word, yr, mon, dom);
                hr = DEFAULT_HOUR;
                mn = 0;
            end
        end else begin
            split_decimal(word, yr, mon, dom);
            if (yr > DEC_YEAR_MAX || md_invalid(mon, dom))
                split_zip(word, yr, mon, dom);
        end
        if (md_invalid(mon, dom))
            return '0;

        // March-based civil day count, 400-year eras (year 0 included)
        yy   = (mon <= 2) ? yr - 1 : yr;
        era  = (yy >= 0 ? yy : yy - 399) / 400;
        yoe  = yy - era * 400;
        mp   = (mon > 2) ? mon - 3 : mon + 9;
        days = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5
               - 719468 + dom - 1;
        secs = days * 86400 + hr * 3600 + mn * 60 - UTC8_OFFSET;
        return secs[44:0];
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------

    // mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(15) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] word,
                                   input logic ht, input logic signed [44:0] want,
                                   input logic signed [44:0] got);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: word=%h has_time=%0b want=%0d got=%0d",
                     $time, what, word, ht, want, got);
    endtask

    // one input beat; returns at the edge that accepted it
    task automatic send_word(input logic [31:0] word, input logic ht);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? gap_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_packed_value <= word;
        i_has_time     <= ht;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_epochs.push_back('{word, ht, epoch_from_word(word, ht, year_cap)});
        n_words_sent++;
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_epochs.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the pipeline empty
    task automatic write_year_cap(input logic [11:0] cap);
        i_cfg_valid <= 1'b1;
        i_year_cap  <= cap;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        year_cap = cap;
        n_cfg_writes++;
    endtask

    // Random date word. Most are well formed so the decode gets past its
    // range checks; the rest are near misses and raw noise.
    task automatic pick_word(output logic [31:0] word, output logic ht);
        int          sel;
        logic [15:0] mins;
        logic [10:0] md;
        int unsigned yr;
        sel = $urandom_range(99);
        mins = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1439));
        md   = 11'($urandom_range(12, 1) * 100 + $urandom_range(31, 1));
        if (sel < 30) begin
            // packed with time, any year offset so some pass the cap
            word = {mins, 5'($urandom), md};
            ht   = 1'b1;
        end else if (sel < 50) begin
            // decimal date only
            yr   = ($urandom_range(3) == 0) ? $urandom_range(9999) : $urandom_range(2100, 1900);
            word = yr * 10000 + $urandom_range(12, 1) * 100 + $urandom_range(31, 1);
            ht   = 1'b0;
        end else if (sel < 60) begin
            // decimal with time flag: minutes field too big, so decimal wins
            yr   = $urandom_range(429495, 9438);
            word = yr * 10000 + $urandom_range(12, 1) * 100 + $urandom_range(31, 1);
            ht   = 1'b1;
        end else if (sel < 70) begin
            // packed low half without time: decimal read fails, falls back
            word = {16'($urandom), 5'($urandom), md};
            ht   = 1'b0;
        end else if (sel < 80) begin
            // near misses around month and day limits
            md = 11'($urandom_range(13) * 100 + $urandom_range(32));
            ht = 1'($urandom);
            if ($urandom_range(1))
                word = {mins, 5'($urandom), md};
            else
                word = $urandom_range(2101, 1990) * 10000 + md;
        end else begin
            word = $urandom;
            ht   = 1'($urandom);
        end
    endtask

    task automatic send_random(input int count);
        logic [31:0] word;
        logic        ht;
        repeat (count) begin
            pick_word(word, ht);
            send_word(word, ht);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall runs plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            stall_left = gap_len() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_epoch_beat exp_beat;
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b1)
                n_input_blocked++;
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_epochs.size() == 0) begin
                    report_mismatch("unexpected result", '0, 1'b0, '0, o_epoch_seconds);
                end else begin
                    exp_beat = pending_epochs.pop_front();
                    n_epochs_checked++;
                    if (o_epoch_seconds !== exp_beat.secs)
                        report_mismatch("epoch_seconds", exp_beat.word, exp_beat.has_time,
                                        exp_beat.secs, o_epoch_seconds);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // field extremes, every fallback path, rollover and year zero
    task automatic test_directed();
        send_word(32'h0000_0065, 1'b1);      // packed 2004-01-01 00:00
        send_word(32'h059F_ACCF, 1'b1);      // packed 2025-12-31 23:59
        send_word(32'h05A0_ACCF, 1'b1);      // 24:00 -> decimal reread
        send_word(32'h0000_B065, 1'b1);      // 2026 above reset cap
        send_word(32'h003C_F865, 1'b1);      // year offset 31
        send_word(32'h0000_500F, 1'b1);      // packed month zero
        send_word(32'h0000_0515, 1'b1);      // packed month 13
        send_word(32'h0000_012C, 1'b1);      // packed day zero
        send_word(32'h0000_0084, 1'b1);      // packed day 32
        send_word(32'h0000_07FF, 1'b1);      // month/day field all ones
        send_word(32'h02D0_A0E7, 1'b1);      // packed Feb 31 2024 noon, rolls over
        send_word(32'd20250315, 1'b0);
        send_word(32'd101, 1'b0);            // year zero, Jan 1
        send_word(32'd229, 1'b0);            // year zero is leap
        send_word(32'd1231, 1'b0);
        send_word(32'd21010101, 1'b0);       // past 2100 -> packed reread
        send_word(32'd21001231, 1'b0);
        send_word(32'd20230231, 1'b0);       // Feb 31 -> Mar 3
        send_word(32'd20240230, 1'b0);       // leap Feb 30 -> Mar 1
        send_word(32'd19700101, 1'b0);
        send_word(32'd19691231, 1'b0);
        send_word(32'd20241399, 1'b0);       // decimal month 13 -> packed reread
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'd4294961231, 1'b1);     // largest decimal year that decodes
    endtask

    // random words at the reset year cap
    task automatic test_random_reset_cap();
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        send_random(300);
    endtask

    // walk the cap through its extremes and a few random points; idle
    // levels change per phase, one phase with none at all
    task automatic test_year_cap_sweep();
        logic [11:0] caps[6];
        caps = '{YEAR_CAP_MIN, YEAR_CAP_MAX, 12'd2019, 12'd2035,
                 12'($urandom_range(YEAR_CAP_MAX, YEAR_CAP_MIN)),
                 12'($urandom_range(YEAR_CAP_MAX, YEAR_CAP_MIN))};
        foreach (caps[k]) begin
            wait_idle();
            write_year_cap(caps[k]);
            src_idle_pct   = (k == 2) ? 0 : $urandom_range(40);
            sink_stall_pct = (k == 2) ? 0 : $urandom_range(40);
            send_random(240);
        end
        wait_idle();
        write_year_cap(YEAR_CAP_RESET);
    endtask

    // output held off long enough that the pipe fills and o_stall rises
    task automatic test_output_holdoff();
        wait_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 60;
        send_random(50);
        sink_stall_pct = 25;
        send_random(50);
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_drain_and_resume();
        src_idle_pct   = 15;
        sink_stall_pct = 15;
        repeat (4) begin
            send_random(25);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain_cycles;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_packed_value <= '0;
        i_has_time     <= 1'b0;
        i_stall        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_year_cap     <= YEAR_CAP_RESET;
        year_cap       = YEAR_CAP_RESET;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        stall_left     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_reset_cap();
        test_year_cap_sweep();
        test_output_holdoff();
        test_drain_and_resume();

        // drain with a bound, then let the pipe settle
        i_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_epochs.size() != 0 && drain_cycles < 4000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        foreach (pending_epochs[k])
            report_mismatch("missing result", pending_epochs[k].word,
                            pending_epochs[k].has_time, pending_epochs[k].secs, '0);

        $display("run covered %0d date words, %0d results checked, %0d year cap writes",
                 n_words_sent, n_epochs_checked, n_cfg_writes);
        $display("input held back for %0d cycles, %0d mismatches",
                 n_input_blocked, n_errors);
        if (n_errors == 0)
            $display("packed_date_to_epoch_unit regression: pass");
        else
            $display("packed_date_to_epoch_unit regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_epochs.size());
        $display("packed_date_to_epoch_unit regression: fail");
        $finish;
    end

endmodule
